/* sv/rpfa_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the reference-counted page frame allocator.
package rpfa_pkg;

   localparam int ADDR_W     = 64;
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int REF_OUT_W  = 8;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_ADDREF = 2'd2,
      OP_INIT   = 2'd3
   } rpfa_op_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NO_FREE   = 2'd1,
      STS_BAD_ADDR  = 2'd2,
      STS_COUNT_ERR = 2'd3
   } rpfa_status_type;

   typedef enum logic {
      CSR_MEM_BASE   = 1'b0,
      CSR_KERNEL_END = 1'b1
   } rpfa_csr_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_UPDATE,
      ST_INIT_OFF,
      ST_INIT_START,
      ST_INIT_FILL
   } rpfa_state_type;

   typedef struct packed {
      rpfa_op_type             req_type;
      logic [ADDR_W-1:0]       phys_addr;
   } rpfa_req_type;

   typedef struct packed {
      rpfa_status_type         status;
      logic [ADDR_W-1:0]       page_addr;
      logic [REF_OUT_W-1:0]    ref_count;
      logic                    page_released;
   } rpfa_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;
      logic chk;
      logic init_off;
      logic init_start;
      logic rd_stack;
      logic rd_cnt;
      logic clear_step;
      logic fill_step;
      logic finish;
   } rpfa_cmd_type;

   // Datapath to controller
   typedef struct packed {
      rpfa_op_type op;
      rpfa_op_type in_op;
      logic        stack_empty;
      logic        clear_last;
      logic        fill_done;
      logic        out_free;
   } rpfa_sts_type;

endpackage

/* sv/rpfa_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the page frame allocator.
module rpfa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rpfa_pkg::rpfa_sts_type sts,
   output rpfa_pkg::rpfa_cmd_type cmd
);
   import rpfa_pkg::*;

   rpfa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (sts.in_op)
                  OP_ALLOC:  state_in = ST_READ;
                  OP_FREE:   state_in = ST_CHECK;
                  OP_ADDREF: state_in = ST_CHECK;
                  OP_INIT:   state_in = ST_INIT_OFF;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_CHECK:      state_in = ST_READ;
         ST_READ:       state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_INIT_OFF:   state_in = ST_INIT_START;
         ST_INIT_START: state_in = ST_INIT_FILL;
         ST_INIT_FILL: begin
            if (sts.fill_done) begin
               state_in = ST_UPDATE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR:      cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_CHECK:      cmd.chk = 1'b1;
         ST_READ: begin
            cmd.rd_stack = (sts.op == OP_ALLOC) && !sts.stack_empty;
            cmd.rd_cnt   = (sts.op == OP_FREE) || (sts.op == OP_ADDREF);
         end
         ST_UPDATE:     cmd.finish = sts.out_free;
         ST_INIT_OFF:   cmd.init_off = 1'b1;
         ST_INIT_START: cmd.init_start = 1'b1;
         ST_INIT_FILL:  cmd.fill_step = !sts.fill_done;
         default:       cmd = '0;
      endcase
   end

endmodule

/* sv/rpfa_dp.sv */
`timescale 1ns / 1ps
// Datapath of the page frame allocator: config, count and stack memories, result register.
module rpfa_dp #(
   parameter int NUM_PAGES = 32768,
   parameter int MAX_REF   = 255
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rpfa_pkg::rpfa_req_type         req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rpfa_pkg::rpfa_rsp_type         rsp_payload,
   input  logic                           csr_we,
   input  rpfa_pkg::rpfa_csr_type         csr_index,
   input  logic [rpfa_pkg::ADDR_W-1:0]    csr_wdata,
   input  rpfa_pkg::rpfa_cmd_type         cmd,
   output rpfa_pkg::rpfa_sts_type         sts
);
   import rpfa_pkg::*;

   localparam int IDX_W = $clog2(NUM_PAGES);
   localparam int SC_W  = $clog2(NUM_PAGES + 1);
   localparam int CNT_W = $clog2(MAX_REF + 1);
   localparam int Q_W   = ADDR_W - PAGE_SHIFT;
   localparam logic [SC_W-1:0]  NP_SC   = SC_W'(NUM_PAGES);
   localparam logic [SC_W-1:0]  NP_LAST = SC_W'(NUM_PAGES - 1);
   localparam logic [Q_W-1:0]   NP_Q    = Q_W'(NUM_PAGES);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REF);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
   localparam logic [ADDR_W-1:0] BASE_RST = ADDR_W'(64'h8000_0000);

   function automatic logic [REF_OUT_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
      logic [CNT_W+REF_OUT_W-1:0] w;
      w = {{REF_OUT_W{1'b0}}, c};
      return w[REF_OUT_W-1:0];
   endfunction

   logic [ADDR_W-1:0] mem_base_ff, mem_base_in;
   logic [ADDR_W-1:0] kend_ff, kend_in;
   rpfa_op_type       op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] off_ff, off_in;
   logic              ge_ok_ff, ge_ok_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              addr_ok_ff, addr_ok_in;
   logic [SC_W-1:0]   sc_ff, sc_in;
   logic [SC_W-1:0]   sweep_ff, sweep_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rpfa_rsp_type      rsp_ff, rsp_in;
   logic [CNT_W-1:0]  cnt_rd_ff;
   logic [IDX_W-1:0]  stk_rd_ff;

   logic [CNT_W-1:0]  cnt_mem [NUM_PAGES];
   logic [IDX_W-1:0]  stk_mem [NUM_PAGES];

   logic              cnt_we, stk_we;
   logic [IDX_W-1:0]  cnt_waddr, stk_waddr, stk_wdata;
   logic [CNT_W-1:0]  cnt_wdata;

   logic [IDX_W-1:0]  idx_c;
   logic [Q_W-1:0]    q_c;
   logic              aligned_c;
   logic [SC_W-1:0]   sc_dec;
   logic [SC_W-1:0]   start_c;
   logic [CNT_W-1:0]  cnt_dec, cnt_inc;

   assign idx_c     = off_ff[PAGE_SHIFT +: IDX_W];
   assign q_c       = off_ff[ADDR_W-1:PAGE_SHIFT];
   assign aligned_c = (off_ff[PAGE_SHIFT-1:0] == '0);
   assign sc_dec    = sc_ff - SC_W'(1);
   assign cnt_dec   = cnt_rd_ff - ONE_CNT;
   assign cnt_inc   = cnt_rd_ff + ONE_CNT;

   // First page of an init sweep, rounded up and clipped to the page count
   always_comb begin
      if (!ge_ok_ff) begin
         start_c = '0;
      end else if (q_c >= NP_Q) begin
         start_c = NP_SC;
      end else begin
         start_c = SC_W'(idx_c) + SC_W'(!aligned_c);
      end
   end

   always_comb begin
      mem_base_in  = mem_base_ff;
      kend_in      = kend_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      off_in       = off_ff;
      ge_ok_in     = ge_ok_ff;
      idx_in       = idx_ff;
      addr_ok_in   = addr_ok_ff;
      sc_in        = sc_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cnt_we       = 1'b0;
      cnt_waddr    = sweep_ff[IDX_W-1:0];
      cnt_wdata    = '0;
      stk_we       = 1'b0;
      stk_waddr    = sc_ff[IDX_W-1:0];
      stk_wdata    = sweep_ff[IDX_W-1:0];

      if (csr_we) begin
         case (csr_index)
            CSR_MEM_BASE:   mem_base_in = csr_wdata;
            CSR_KERNEL_END: kend_in     = csr_wdata;
            default:        mem_base_in = mem_base_ff;
         endcase
      end

      if (cmd.load_req) begin
         op_in   = req_payload.req_type;
         addr_in = req_payload.phys_addr;
      end

      if (cmd.chk) begin
         off_in   = addr_ff - mem_base_ff;
         ge_ok_in = (addr_ff >= mem_base_ff) && (addr_ff >= kend_ff);
      end

      if (cmd.init_off) begin
         off_in   = kend_ff - mem_base_ff;
         ge_ok_in = (kend_ff > mem_base_ff);
      end

      if (cmd.rd_cnt) begin
         idx_in     = idx_c;
         addr_ok_in = ge_ok_ff && aligned_c && (q_c < NP_Q);
      end

      if (cmd.init_start) begin
         sweep_in = start_c;
         sc_in    = '0;
      end

      if (cmd.clear_step) begin
         cnt_we   = 1'b1;
         sweep_in = sweep_ff + SC_W'(1);
      end

      if (cmd.fill_step) begin
         cnt_we   = 1'b1;
         stk_we   = 1'b1;
         sweep_in = sweep_ff + SC_W'(1);
         sc_in    = sc_ff + SC_W'(1);
      end

      if (cmd.finish) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = STS_OK;
         rsp_in.page_addr     = '0;
         rsp_in.ref_count     = '0;
         rsp_in.page_released = 1'b0;
         case (op_ff)
            OP_ALLOC: begin
               if (sc_ff == '0) begin
                  rsp_in.status = STS_NO_FREE;
               end else begin
                  sc_in            = sc_dec;
                  cnt_we           = 1'b1;
                  cnt_waddr        = stk_rd_ff;
                  cnt_wdata        = ONE_CNT;
                  rsp_in.page_addr = mem_base_ff + (ADDR_W'(stk_rd_ff) << PAGE_SHIFT);
                  rsp_in.ref_count = cnt_out(ONE_CNT);
               end
            end
            OP_FREE: begin
               if (!addr_ok_ff) begin
                  rsp_in.status = STS_BAD_ADDR;
               end else if (cnt_rd_ff == '0) begin
                  rsp_in.status = STS_COUNT_ERR;
               end else begin
                  cnt_we           = 1'b1;
                  cnt_waddr        = idx_ff;
                  cnt_wdata        = cnt_dec;
                  rsp_in.ref_count = cnt_out(cnt_dec);
                  // Return the page to the stack unless the stack is full
                  if ((cnt_dec == '0) && (sc_ff < NP_SC)) begin
                     stk_we               = 1'b1;
                     stk_wdata            = idx_ff;
                     sc_in                = sc_ff + SC_W'(1);
                     rsp_in.page_released = 1'b1;
                  end
               end
            end
            OP_ADDREF: begin
               if (!addr_ok_ff) begin
                  rsp_in.status = STS_BAD_ADDR;
               end else if (cnt_rd_ff >= MAX_CNT) begin
                  rsp_in.status    = STS_COUNT_ERR;
                  rsp_in.ref_count = cnt_out(cnt_rd_ff);
               end else begin
                  cnt_we           = 1'b1;
                  cnt_waddr        = idx_ff;
                  cnt_wdata        = cnt_inc;
                  rsp_in.ref_count = cnt_out(cnt_inc);
               end
            end
            default: begin
               rsp_in.status = STS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_base_ff  <= BASE_RST;
         kend_ff      <= BASE_RST;
         sc_ff        <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mem_base_ff  <= mem_base_in;
         kend_ff      <= kend_in;
         sc_ff        <= sc_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      addr_ff    <= addr_in;
      off_ff     <= off_in;
      ge_ok_ff   <= ge_ok_in;
      idx_ff     <= idx_in;
      addr_ok_ff <= addr_ok_in;
      rsp_ff     <= rsp_in;
   end

   // Count memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cmd.rd_cnt) begin
         cnt_rd_ff <= cnt_mem[idx_c];
      end
   end

   // Free stack memory: one write port, one registered read port at the top
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (cmd.rd_stack) begin
         stk_rd_ff <= stk_mem[sc_dec[IDX_W-1:0]];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sts.op          = op_ff;
   assign sts.in_op       = req_payload.req_type;
   assign sts.stack_empty = (sc_ff == '0);
   assign sts.clear_last  = (sweep_ff == NP_LAST);
   assign sts.fill_done   = (sweep_ff >= NP_SC);
   assign sts.out_free    = !rsp_valid_ff || rsp_ready;

endmodule

/* sv/refcounted_page_frame_allocator_top.sv */
`timescale 1ns / 1ps
// Top level of the reference-counted page frame allocator.
//
// Physical page allocator with an 8-bit-visible reference count per page and a
// LIFO stack of free page indices. Page i sits at mem_base + i*PAGE_BYTES.
// Requests: allocate pops the top page and sets its count to one; free checks
// the address, decrements the count and pushes the page back when the count
// reaches zero; add reference increments the count, saturating at MAX_REF;
// initialize empties the stack and pushes every page from kernel_end_addr
// (rounded up to a page) to the last one, in ascending order, zeroing counts.
// Every request yields exactly one result item. After reset the block clears
// the count memory one entry per cycle and holds req_ready low meanwhile (CSR
// writes are taken as usual). An allocate runs a stack read and an update, a
// free or add reference an address check, count read and update, and an
// initialize an offset step, a start step and a fill of one page per cycle. The
// steps are set by the single read and single write port of the count and
// stack memories and the read-modify-write through them; one item is in work
// at a time. A finished result sits in an output register, so a stalled rsp
// side only delays the final update of the next item, never the accept. The
// stack starts empty: issue an initialize before allocating. Write the CSRs
// only while no item is in flight.
module refcounted_page_frame_allocator_top #(
   parameter int NUM_PAGES = 32768,
   parameter int MAX_REF   = 255
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  rpfa_pkg::rpfa_req_type      req_payload,
   // Result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rpfa_pkg::rpfa_rsp_type      rsp_payload,
   // CSR write port: index 0 mem_base, index 1 kernel_end_addr
   input  logic                        csr_we,
   input  rpfa_pkg::rpfa_csr_type      csr_index,
   input  logic [rpfa_pkg::ADDR_W-1:0] csr_wdata
);
   import rpfa_pkg::*;

   rpfa_cmd_type cmd;
   rpfa_sts_type sts;

   // Sequencer: picks the steps of each request and gates the final update
   // on a free output register.
   rpfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: config registers, address check, count and stack memories,
   // stack pointer, sweep counter and result register.
   rpfa_dp #(
      .NUM_PAGES (NUM_PAGES),
      .MAX_REF   (MAX_REF)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
